FILE: rtl/hgr_pkg.sv
// Shared types, constants and saturating word arithmetic for the gating rate pipeline.
// Used by hgr_div, hgr_exp and hh_gating_rate; depends on nothing.
package hgr_pkg;

   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int QUOT_W  = DATA_W + FRAC_W;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int EXP_W   = 3;
   localparam int IN_USED = 10 * DATA_W + EXP_W;
   localparam int IN_TDATA_W = ((IN_USED + 7) / 8) * 8;

   localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] ONE_Q    = 32'h0001_0000;

   localparam logic [EXP_W-1:0] EXP_MIN = 3'd1;
   localparam logic [EXP_W-1:0] EXP_MAX = 3'd4;

   // log2(e) with 32 fraction bits; polynomial terms already at 16 fraction bits
   localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
   localparam logic [15:0] C1_Q = 16'd45599;
   localparam logic [15:0] C2_Q = 16'd14752;
   localparam logic [15:0] C3_Q = 16'd5183;

   typedef struct packed {
      logic              sat;
      logic [DATA_W-1:0] val;
   } satw_type;

   typedef struct packed {
      logic              sat;
      logic [EXP_W-1:0]  n;
      logic [DATA_W-1:0] xg;
      logic [DATA_W-1:0] phi;
      logic [DATA_W-1:0] t0;
      logic [DATA_W-1:0] t1;
      logic [DATA_W-1:0] m;
      logic [DATA_W-1:0] op_a;
      logic [DATA_W-1:0] op_b;
      logic [DATA_W-1:0] op_c;
   } pipe_type;

   function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] a);
      return a[DATA_W-1] ? (~a + 1'b1) : a;
   endfunction

   function automatic satw_type add_q(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      satw_type r;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      r.sat = s[DATA_W] ^ s[DATA_W-1];
      r.val = r.sat ? (s[DATA_W] ? WORD_MIN : WORD_MAX) : s[DATA_W-1:0];
      return r;
   endfunction

   function automatic satw_type sub_q(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      satw_type r;
      s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      r.sat = s[DATA_W] ^ s[DATA_W-1];
      r.val = r.sat ? (s[DATA_W] ? WORD_MIN : WORD_MAX) : s[DATA_W-1:0];
      return r;
   endfunction

   function automatic satw_type neg_q(input logic [DATA_W-1:0] a);
      satw_type r;
      r.sat = (a == WORD_MIN);
      r.val = r.sat ? WORD_MAX : (~a + 1'b1);
      return r;
   endfunction

   // signed word from a magnitude and a sign, saturating
   function automatic satw_type to_word(input logic neg, input logic [QUOT_W-1:0] q);
      logic              big;
      logic [DATA_W-1:0] lo;
      satw_type          r;
      big = (q[QUOT_W-1:DATA_W] != '0);
      lo  = q[DATA_W-1:0];
      r.sat = big || (neg ? (lo > WORD_MIN) : (lo > WORD_MAX));
      if (r.sat) begin
         r.val = neg ? WORD_MIN : WORD_MAX;
      end else begin
         r.val = neg ? (~lo + 1'b1) : lo;
      end
      return r;
   endfunction

   // drop the fraction bits of a full product magnitude, then saturate
   function automatic satw_type mul_fin(input logic [PROD_W-1:0] p, input logic neg);
      return to_word(neg, p[PROD_W-1:FRAC_W]);
   endfunction

endpackage

FILE: rtl/hh_gating_rate.sv
// Top level of the gating rate pipeline: dX/dt = phi*(x_inf(V)-X)/tau(V) in Q16.16.
// Instantiates hgr_div and hgr_exp; depends on hgr_pkg.
//
// One gate evaluation enters per clock while the result side does not stall; the three
// chained 48-stage restoring dividers (one quotient bit per stage) make up most of the
// pipeline's depth. The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall on the result side holds every stage. Items with
// integrate_enable clear are taken and dropped.
module hh_gating_rate (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // from bit 0: membrane_voltage, gate_value, rate_factor, half_act_voltage, act_slope,
   // tau_base, tau_amp, tau_half_voltage, tau_slope, tau_denom_offset, tau_exponent, zero fill
   input  logic [hgr_pkg::IN_TDATA_W-1:0]   req_tdata,
   // bit 0: integrate_enable
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // bits 31:0: gate_rate
   output logic [hgr_pkg::DATA_W-1:0]       rsp_tdata,
   // bit 0: rate_saturated
   output logic [0:0]                       rsp_tuser
);

   localparam int DW = hgr_pkg::DATA_W;
   localparam int EW = hgr_pkg::EXP_W;

   logic adv;

   // input capture
   logic                        r0_vld_ff;
   logic [hgr_pkg::IN_USED-1:0] r0_data_ff;

   // differences
   logic                        r1_vld_ff;
   logic [DW-1:0]               r1_d1_ff, r1_d2_ff, r1_sg_ff, r1_ts_ff;
   hgr_pkg::pipe_type           r1_side_ff;
   hgr_pkg::satw_type           d1_in, d2_in;
   hgr_pkg::pipe_type           r1_side_in;
   logic [EW-1:0]               n_raw;

   logic                        da_vld, da_sat, db_sat;
   logic [DW-1:0]               da_q, db_q;
   hgr_pkg::pipe_type           da_side;

   logic                        r2_vld_ff;
   hgr_pkg::pipe_type           r2_side_ff;
   hgr_pkg::pipe_type           r2_side_in;
   hgr_pkg::satw_type           nu_in;

   // power chain
   logic                        pw_src_vld [0:2];
   hgr_pkg::pipe_type           pw_src     [0:2];
   logic                        pm_vld_ff  [0:2];
   logic [hgr_pkg::PROD_W-1:0]  pm_prod_ff [0:2];
   logic                        pm_neg_ff  [0:2];
   hgr_pkg::pipe_type           pm_side_ff [0:2];
   logic                        pw_vld_ff  [0:2];
   hgr_pkg::pipe_type           pw_side_ff [0:2];
   hgr_pkg::pipe_type           pw_side_in [0:2];

   logic                        r3_vld_ff;
   hgr_pkg::pipe_type           r3_side_ff;
   hgr_pkg::pipe_type           r3_side_in;
   hgr_pkg::satw_type           nw_in;

   logic                        ea_vld;
   logic [DW-1:0]               ea_e, eb_e;
   hgr_pkg::pipe_type           ea_side;

   logic                        r4_vld_ff;
   hgr_pkg::pipe_type           r4_side_ff;
   hgr_pkg::pipe_type           r4_side_in;
   hgr_pkg::satw_type           den1_in, den2_in;

   logic                        dc_vld, dc_sat, dd_sat;
   logic [DW-1:0]               dc_q, dd_q;
   hgr_pkg::pipe_type           dc_side;

   logic                        r5_vld_ff;
   hgr_pkg::pipe_type           r5_side_ff;
   hgr_pkg::pipe_type           r5_side_in;
   hgr_pkg::satw_type           tau_in, dx_in;

   logic                        r6_vld_ff;
   logic [hgr_pkg::PROD_W-1:0]  r6_prod_ff;
   logic                        r6_neg_ff;
   hgr_pkg::pipe_type           r6_side_ff;

   logic                        r7_vld_ff;
   hgr_pkg::pipe_type           r7_side_ff;
   hgr_pkg::pipe_type           r7_side_in;
   hgr_pkg::satw_type           num_in;

   logic                        de_vld, de_sat;
   logic [DW-1:0]               de_q;
   hgr_pkg::pipe_type           de_side;

   logic                        out_vld_ff;
   logic [DW-1:0]               out_rate_ff;
   logic                        out_sat_ff;

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   // differences and sideband setup
   always_comb begin
      d1_in = hgr_pkg::sub_q(r0_data_ff[0*DW +: DW], r0_data_ff[3*DW +: DW]);
      d2_in = hgr_pkg::sub_q(r0_data_ff[0*DW +: DW], r0_data_ff[7*DW +: DW]);
      n_raw = r0_data_ff[10*DW +: EW];
      r1_side_in.sat  = d1_in.sat | d2_in.sat;
      if (n_raw < hgr_pkg::EXP_MIN) begin
         r1_side_in.n = hgr_pkg::EXP_MIN;
      end else if (n_raw > hgr_pkg::EXP_MAX) begin
         r1_side_in.n = hgr_pkg::EXP_MAX;
      end else begin
         r1_side_in.n = n_raw;
      end
      r1_side_in.xg   = r0_data_ff[1*DW +: DW];
      r1_side_in.phi  = r0_data_ff[2*DW +: DW];
      r1_side_in.t0   = r0_data_ff[5*DW +: DW];
      r1_side_in.t1   = r0_data_ff[6*DW +: DW];
      r1_side_in.m    = r0_data_ff[9*DW +: DW];
      r1_side_in.op_a = '0;
      r1_side_in.op_b = '0;
      r1_side_in.op_c = '0;
   end

   hgr_div u_div_act (
      .clock(clock), .reset(reset), .adv(adv),
      .vld_i(r1_vld_ff), .a_i(r1_d1_ff), .b_i(r1_sg_ff), .side_i(r1_side_ff),
      .vld_o(da_vld), .q_o(da_q), .sat_o(da_sat), .side_o(da_side)
   );

   hgr_div u_div_tau (
      .clock(clock), .reset(reset), .adv(adv),
      .vld_i(r1_vld_ff), .a_i(r1_d2_ff), .b_i(r1_ts_ff), .side_i(r1_side_ff),
      .vld_o(), .q_o(db_q), .sat_o(db_sat), .side_o()
   );

   // op_a: -u1, op_b: u2, op_c: running power of u2
   always_comb begin
      nu_in           = hgr_pkg::neg_q(da_q);
      r2_side_in      = da_side;
      r2_side_in.sat  = da_side.sat | da_sat | db_sat | nu_in.sat;
      r2_side_in.op_a = nu_in.val;
      r2_side_in.op_b = db_q;
      r2_side_in.op_c = db_q;
   end

   always_comb begin
      hgr_pkg::satw_type r;
      pw_src_vld[0] = r2_vld_ff;
      pw_src[0]     = r2_side_ff;
      for (int i = 1; i < 3; i++) begin
         pw_src_vld[i] = pw_vld_ff[i-1];
         pw_src[i]     = pw_side_ff[i-1];
      end
      for (int i = 0; i < 3; i++) begin
         r             = hgr_pkg::mul_fin(pm_prod_ff[i], pm_neg_ff[i]);
         pw_side_in[i] = pm_side_ff[i];
         // apply this multiply only while the exponent calls for it
         if (pm_side_ff[i].n > EW'(i + 1)) begin
            pw_side_in[i].op_c = r.val;
            pw_side_in[i].sat  = pm_side_ff[i].sat | r.sat;
         end
      end
   end

   always_comb begin
      nw_in           = hgr_pkg::neg_q(pw_side_ff[2].op_c);
      r3_side_in      = pw_side_ff[2];
      r3_side_in.sat  = pw_side_ff[2].sat | nw_in.sat;
      r3_side_in.op_c = nw_in.val;
   end

   hgr_exp u_exp_act (
      .clock(clock), .reset(reset), .adv(adv),
      .vld_i(r3_vld_ff), .x_i(r3_side_ff.op_a), .side_i(r3_side_ff),
      .vld_o(ea_vld), .e_o(ea_e), .side_o(ea_side)
   );

   hgr_exp u_exp_tau (
      .clock(clock), .reset(reset), .adv(adv),
      .vld_i(r3_vld_ff), .x_i(r3_side_ff.op_c), .side_i(r3_side_ff),
      .vld_o(), .e_o(eb_e), .side_o()
   );

   always_comb begin
      den1_in         = hgr_pkg::add_q(hgr_pkg::ONE_Q, ea_e);
      den2_in         = hgr_pkg::add_q(ea_side.m, eb_e);
      r4_side_in      = ea_side;
      r4_side_in.sat  = ea_side.sat | den1_in.sat | den2_in.sat;
      r4_side_in.op_a = den1_in.val;
      r4_side_in.op_b = den2_in.val;
   end

   hgr_div u_div_xinf (
      .clock(clock), .reset(reset), .adv(adv),
      .vld_i(r4_vld_ff), .a_i(hgr_pkg::ONE_Q), .b_i(r4_side_ff.op_a), .side_i(r4_side_ff),
      .vld_o(dc_vld), .q_o(dc_q), .sat_o(dc_sat), .side_o(dc_side)
   );

   hgr_div u_div_tamp (
      .clock(clock), .reset(reset), .adv(adv),
      .vld_i(r4_vld_ff), .a_i(r4_side_ff.t1), .b_i(r4_side_ff.op_b), .side_i(r4_side_ff),
      .vld_o(), .q_o(dd_q), .sat_o(dd_sat), .side_o()
   );

   // op_a: x_inf - X, op_b: tau
   always_comb begin
      tau_in          = hgr_pkg::add_q(dc_side.t0, dd_q);
      dx_in           = hgr_pkg::sub_q(dc_q, dc_side.xg);
      r5_side_in      = dc_side;
      r5_side_in.sat  = dc_side.sat | dc_sat | dd_sat | tau_in.sat | dx_in.sat;
      r5_side_in.op_a = dx_in.val;
      r5_side_in.op_b = tau_in.val;
   end

   always_comb begin
      num_in          = hgr_pkg::mul_fin(r6_prod_ff, r6_neg_ff);
      r7_side_in      = r6_side_ff;
      r7_side_in.sat  = r6_side_ff.sat | num_in.sat;
      r7_side_in.op_a = num_in.val;
   end

   hgr_div u_div_rate (
      .clock(clock), .reset(reset), .adv(adv),
      .vld_i(r7_vld_ff), .a_i(r7_side_ff.op_a), .b_i(r7_side_ff.op_b), .side_i(r7_side_ff),
      .vld_o(de_vld), .q_o(de_q), .sat_o(de_sat), .side_o(de_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_vld_ff  <= 1'b0;
         r1_vld_ff  <= 1'b0;
         r2_vld_ff  <= 1'b0;
         r3_vld_ff  <= 1'b0;
         r4_vld_ff  <= 1'b0;
         r5_vld_ff  <= 1'b0;
         r6_vld_ff  <= 1'b0;
         r7_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pm_vld_ff[i] <= 1'b0;
            pw_vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         // drop transfers with the enable flag clear
         r0_vld_ff <= req_tvalid && req_tuser[0];
         r1_vld_ff <= r0_vld_ff;
         r2_vld_ff <= da_vld;
         for (int i = 0; i < 3; i++) begin
            pm_vld_ff[i] <= pw_src_vld[i];
            pw_vld_ff[i] <= pm_vld_ff[i];
         end
         r3_vld_ff  <= pw_vld_ff[2];
         r4_vld_ff  <= ea_vld;
         r5_vld_ff  <= dc_vld;
         r6_vld_ff  <= r5_vld_ff;
         r7_vld_ff  <= r6_vld_ff;
         out_vld_ff <= de_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r0_data_ff <= req_tdata[hgr_pkg::IN_USED-1:0];
         r1_d1_ff   <= d1_in.val;
         r1_d2_ff   <= d2_in.val;
         r1_sg_ff   <= r0_data_ff[4*DW +: DW];
         r1_ts_ff   <= r0_data_ff[8*DW +: DW];
         r1_side_ff <= r1_side_in;
         r2_side_ff <= r2_side_in;
         for (int i = 0; i < 3; i++) begin
            pm_prod_ff[i] <= hgr_pkg::PROD_W'(hgr_pkg::mag(pw_src[i].op_c))
                             * hgr_pkg::PROD_W'(hgr_pkg::mag(pw_src[i].op_b));
            pm_neg_ff[i]  <= pw_src[i].op_c[DW-1] ^ pw_src[i].op_b[DW-1];
            pm_side_ff[i] <= pw_src[i];
            pw_side_ff[i] <= pw_side_in[i];
         end
         r3_side_ff  <= r3_side_in;
         r4_side_ff  <= r4_side_in;
         r5_side_ff  <= r5_side_in;
         r6_prod_ff  <= hgr_pkg::PROD_W'(hgr_pkg::mag(r5_side_ff.phi))
                        * hgr_pkg::PROD_W'(hgr_pkg::mag(r5_side_ff.op_a));
         r6_neg_ff   <= r5_side_ff.phi[DW-1] ^ r5_side_ff.op_a[DW-1];
         r6_side_ff  <= r5_side_ff;
         r7_side_ff  <= r7_side_in;
         out_rate_ff <= de_q;
         out_sat_ff  <= de_side.sat | de_sat;
      end
   end

   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = out_rate_ff;
   assign rsp_tuser[0] = out_sat_ff;

   // a disabled transfer never enters the pipeline
   a_drop_disabled: assert property (@(posedge clock) disable iff (reset)
      (adv && req_tvalid && !req_tuser[0]) |=> !r0_vld_ff)
      else $error("disabled transfer entered the pipeline");

   // the r1 and r7 valid flags hold while the output is stalled
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (r1_vld_ff == $past(r1_vld_ff)) && (r7_vld_ff == $past(r7_vld_ff)))
      else $error("pipeline moved during a stall");

   // the exponential is never negative
   a_exp_sign: assert property (@(posedge clock) disable iff (reset)
      ea_vld |-> !ea_e[DW-1])
      else $error("negative exponential");

endmodule

FILE: rtl/hgr_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturating Q16.16 result.
// Carries the pipeline sideband alongside; depends on hgr_pkg.
module hgr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        vld_i,
   input  logic [hgr_pkg::DATA_W-1:0]  a_i,
   input  logic [hgr_pkg::DATA_W-1:0]  b_i,
   input  hgr_pkg::pipe_type           side_i,
   output logic                        vld_o,
   output logic [hgr_pkg::DATA_W-1:0]  q_o,
   output logic                        sat_o,
   output hgr_pkg::pipe_type           side_o
);

   localparam int DW    = hgr_pkg::DATA_W;
   localparam int QW    = hgr_pkg::QUOT_W;
   localparam int STEPS = hgr_pkg::QUOT_W;

   logic              vld_ff  [0:STEPS];
   logic [DW-1:0]     na_ff   [0:STEPS];
   logic [DW-1:0]     nb_ff   [0:STEPS];
   logic [DW-1:0]     rem_ff  [0:STEPS];
   logic [QW-1:0]     quot_ff [0:STEPS];
   logic              neg_ff  [0:STEPS];
   logic              aneg_ff [0:STEPS];
   logic              bz_ff   [0:STEPS];
   hgr_pkg::pipe_type side_ff [0:STEPS];

   logic [DW-1:0]     rem_in  [1:STEPS];
   logic [QW-1:0]     quot_in [1:STEPS];

   logic              vld_out_ff;
   logic [DW-1:0]     q_ff;
   logic              sat_ff;
   hgr_pkg::pipe_type side_out_ff;
   hgr_pkg::satw_type res_in;

   always_comb begin
      logic [QW-1:0] dvd;
      logic [DW:0]   trial;
      for (int s = 0; s < STEPS; s++) begin
         dvd   = {na_ff[s], {hgr_pkg::FRAC_W{1'b0}}};
         trial = {rem_ff[s], dvd[QW-1-s]};
         if (trial >= {1'b0, nb_ff[s]}) begin
            rem_in[s+1]  = DW'(trial - {1'b0, nb_ff[s]});
            quot_in[s+1] = {quot_ff[s][QW-2:0], 1'b1};
         end else begin
            rem_in[s+1]  = trial[DW-1:0];
            quot_in[s+1] = {quot_ff[s][QW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (bz_ff[STEPS]) begin
         res_in.sat = 1'b1;
         res_in.val = aneg_ff[STEPS] ? hgr_pkg::WORD_MIN : hgr_pkg::WORD_MAX;
      end else begin
         res_in = hgr_pkg::to_word(neg_ff[STEPS], quot_ff[STEPS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) begin
            vld_ff[s] <= 1'b0;
         end
         vld_out_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= vld_i;
         for (int s = 1; s <= STEPS; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         vld_out_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         na_ff[0]   <= hgr_pkg::mag(a_i);
         nb_ff[0]   <= hgr_pkg::mag(b_i);
         rem_ff[0]  <= '0;
         quot_ff[0] <= '0;
         neg_ff[0]  <= a_i[DW-1] ^ b_i[DW-1];
         aneg_ff[0] <= a_i[DW-1];
         bz_ff[0]   <= (b_i == '0);
         side_ff[0] <= side_i;
         for (int s = 1; s <= STEPS; s++) begin
            na_ff[s]   <= na_ff[s-1];
            nb_ff[s]   <= nb_ff[s-1];
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
            neg_ff[s]  <= neg_ff[s-1];
            aneg_ff[s] <= aneg_ff[s-1];
            bz_ff[s]   <= bz_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
         q_ff        <= res_in.val;
         sat_ff      <= res_in.sat;
         side_out_ff <= side_ff[STEPS];
      end
   end

   assign vld_o  = vld_out_ff;
   assign q_o    = q_ff;
   assign sat_o  = sat_ff;
   assign side_o = side_out_ff;

endmodule

FILE: rtl/hgr_exp.sv
// Pipelined fixed-point exponential: 2^k times a cubic in the fraction of x*log2(e).
// Eight register stages, one multiply each at most; depends on hgr_pkg.
module hgr_exp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        vld_i,
   input  logic [hgr_pkg::DATA_W-1:0]  x_i,
   input  hgr_pkg::pipe_type           side_i,
   output logic                        vld_o,
   output logic [hgr_pkg::DATA_W-1:0]  e_o,
   output hgr_pkg::pipe_type           side_o
);

   localparam int DW    = hgr_pkg::DATA_W;
   localparam int FW    = hgr_pkg::FRAC_W;
   localparam int NST   = 8;
   localparam int PW    = FW + 1;
   localparam int SH_W  = PW + DW - 2;

   logic              vld_ff  [0:NST-1];
   hgr_pkg::pipe_type side_ff [0:NST-1];

   logic [DW-1:0]     xm_ff;
   logic              xs_ff;
   logic [DW+32:0]    prod_ff;
   logic              ps_ff;
   logic [15:0]       k_ff [2:6];
   logic [FW-1:0]     f_ff [2:4];
   logic [28:0]       h3_ff;
   logic [30:0]       h2_ff;
   logic [31:0]       h1_ff;
   logic [PW-1:0]     p_ff;
   logic [DW-1:0]     e_ff;

   hgr_pkg::satw_type y_in;
   logic [15:0]       t2_in;
   logic [15:0]       t1_in;
   logic [DW-1:0]     e_in;
   logic [15:0]       rsh_in;
   logic [SH_W-1:0]   wide_in;

   always_comb begin
      y_in  = hgr_pkg::to_word(ps_ff, hgr_pkg::QUOT_W'(prod_ff[DW+32:32]));
      t2_in = hgr_pkg::C2_Q + 16'(h3_ff >> FW);
      t1_in = hgr_pkg::C1_Q + 16'(h2_ff >> FW);
   end

   // scale by 2^k, saturating on the high side and flushing to zero on the low side
   always_comb begin
      rsh_in  = ~k_ff[6] + 1'b1;
      wide_in = SH_W'(p_ff) << k_ff[6][4:0];
      if (!k_ff[6][15]) begin
         if (k_ff[6] >= 16'(DW - 1) || wide_in > SH_W'(hgr_pkg::WORD_MAX)) begin
            e_in = hgr_pkg::WORD_MAX;
         end else begin
            e_in = wide_in[DW-1:0];
         end
      end else if (rsh_in >= 16'(DW)) begin
         e_in = '0;
      end else begin
         e_in = DW'(p_ff) >> rsh_in[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= vld_i;
         for (int s = 1; s < NST; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_i;
         for (int s = 1; s < NST; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         xm_ff   <= hgr_pkg::mag(x_i);
         xs_ff   <= x_i[DW-1];
         prod_ff <= (DW+33)'(xm_ff) * (DW+33)'(hgr_pkg::LOG2E_Q32);
         ps_ff   <= xs_ff;
         k_ff[2] <= y_in.val[DW-1:FW];
         f_ff[2] <= y_in.val[FW-1:0];
         h3_ff   <= 29'(f_ff[2]) * 29'(hgr_pkg::C3_Q);
         k_ff[3] <= k_ff[2];
         f_ff[3] <= f_ff[2];
         h2_ff   <= 31'(f_ff[3]) * 31'(t2_in);
         k_ff[4] <= k_ff[3];
         f_ff[4] <= f_ff[3];
         h1_ff   <= 32'(f_ff[4]) * 32'(t1_in);
         k_ff[5] <= k_ff[4];
         p_ff    <= PW'(hgr_pkg::ONE_Q) + PW'(h1_ff >> FW);
         k_ff[6] <= k_ff[5];
         e_ff    <= e_in;
      end
   end

   assign vld_o  = vld_ff[NST-1];
   assign side_o = side_ff[NST-1];
   assign e_o    = e_ff;

endmodule
